// ===== src/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// Action and status codes, controller state, and the command and status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH_DEF      = 128;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int ACTION_W    = 2;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int OCCUPANCY_W = 8;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_OK        = 2'd0,
    RES_OVERFLOW  = 2'd1,
    RES_UNDERFLOW = 2'd2
  } res_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctl_state_t;

  typedef struct packed {
    logic take;
    logic wr;
    logic rd;
    logic front;
    res_t status;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } sts_t;

endpackage

// ===== src/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl: controller for the circular deque
// Decodes each accepted word against the full and empty flags, sequences
// the memory access and the output register load, and owns both handshakes.
// ----------------------------------------------------------------------------
module cdq_ctrl
  import cdq_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [ACTION_W-1:0] in_action,
  output logic                out_valid,
  input  logic                out_ready,
  input  sts_t                sts,
  output cmd_t                cmd
);

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  act_t       act;

  assign act       = act_t'(in_action);
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.status    = RES_OK;
    cmd.front     = (act == ACT_PUSH_FRONT) || (act == ACT_POP_FRONT);
    if (act inside {ACT_PUSH_FRONT, ACT_PUSH_BACK}) begin
      if (sts.full) begin
        cmd.status = RES_OVERFLOW;
      end
    end else begin
      if (sts.empty) begin
        cmd.status = RES_UNDERFLOW;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          cmd.wr    = (act inside {ACT_PUSH_FRONT, ACT_PUSH_BACK}) && !sts.full;
          cmd.rd    = (act inside {ACT_POP_FRONT, ACT_POP_BACK}) && !sts.empty;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || out_ready) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_wr_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |-> !sts.full) else $error("push issued while full");
  a_rd_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !sts.empty) else $error("pop issued while empty");
  a_take_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> state_r == ST_EXEC) else $error("accepted word not executed");
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r) else $error("loaded result not presented");
`endif

endmodule

// ===== src/cdq_dp.sv =====
// ----------------------------------------------------------------------------
// cdq_dp: datapath for the circular deque
// Ring memory with one write and one registered read port, head and tail
// pointers that wrap at the depth, the entry count and the output register.
// ----------------------------------------------------------------------------
module cdq_dp
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  cmd_t                   cmd,
  input  logic [VALUE_W-1:0]     in_push_value,
  output sts_t                   sts,
  output logic [STATUS_W-1:0]    out_status,
  output logic [VALUE_W-1:0]     out_pop_value,
  output logic [OCCUPANCY_W-1:0] out_occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]          head_r, head_nxt;
  logic [AW-1:0]          tail_r, tail_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [DATA_WIDTH-1:0]  rd_data_r;
  res_t                   res_r;
  logic                   popped_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [VALUE_W-1:0]     out_pop_value_r;
  logic [OCCUPANCY_W-1:0] out_occupancy_r;

  logic [AW-1:0]          head_inc, head_dec, tail_inc, tail_dec;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic [VALUE_W-1:0]     pop_ext;

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));

  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
  assign tail_dec = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - AW'(1);

  assign wr_data = DATA_WIDTH'($signed(in_push_value));
  assign rd_addr = cmd.front ? head_r : tail_r;
  assign pop_ext = popped_r ? VALUE_W'($signed(rd_data_r)) : '0;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    wr_addr   = head_r;
    if (cmd.wr) begin
      count_nxt = count_r + CW'(1);
      if (sts.empty) begin
        wr_addr = head_r;
      end else if (cmd.front) begin
        wr_addr  = head_dec;
        head_nxt = head_dec;
      end else begin
        wr_addr  = tail_inc;
        tail_nxt = tail_inc;
      end
    end else if (cmd.rd) begin
      count_nxt = count_r - CW'(1);
      if (count_r == CW'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end else if (cmd.front) begin
        head_nxt = head_inc;
      end else begin
        tail_nxt = tail_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_r    <= cmd.status;
      popped_r <= cmd.rd;
    end
    if (cmd.load) begin
      out_status_r    <= res_r;
      out_pop_value_r <= pop_ext;
      out_occupancy_r <= OCCUPANCY_W'(count_r);
    end
  end

  assign out_status    = out_status_r;
  assign out_pop_value = out_pop_value_r;
  assign out_occupancy = out_occupancy_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("entry count above depth");
  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (head_r == tail_r)) else $error("empty with split pointers");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr |=> count_r == $past(count_r) + CW'(1)) else $error("push count slip");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> count_r == $past(count_r) - CW'(1)) else $error("pop count slip");
`endif

endmodule

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring memory
// Push or pop at either end; every word returns a status, the popped value
// and the occupancy after the word.
// ----------------------------------------------------------------------------
//   channel   direction  handshake             payload
//   in_       input      in_valid / in_ready   in_action, in_push_value
//   out_      output     out_valid / out_ready out_status, out_pop_value,
//                                              out_occupancy
//
// The accept cycle updates the pointers and uses the memory port, whose
// registered read data feeds the output register from the execute state
// once the output register is free.
// Reset clears the pointers and the count; the memory is not cleared.
// A result waits in the output register while the next word is accepted;
// that word's result is held back until the output register is free.
// ----------------------------------------------------------------------------
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [ACTION_W-1:0]    in_action,
  input  logic [VALUE_W-1:0]     in_push_value,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [STATUS_W-1:0]    out_status,
  output logic [VALUE_W-1:0]     out_pop_value,
  output logic [OCCUPANCY_W-1:0] out_occupancy
);

  cmd_t cmd;
  sts_t sts;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cdq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_push_value (in_push_value),
    .sts           (sts),
    .out_status    (out_status),
    .out_pop_value (out_pop_value),
    .out_occupancy (out_occupancy)
  );

endmodule
